/* hdl/xts_pkg.sv */
package xts_pkg;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int TDATA_BITS  = 56;

	typedef enum logic [3:0] {
		M_TEXT,
		M_LT,
		M_PI,
		M_BANG,
		M_BANG_DASH,
		M_COMMENT,
		M_CDATA_OPEN,
		M_CDATA,
		M_DECL,
		M_CLOSE,
		M_NAME,
		M_ATTR,
		M_HALT
	} scan_mode_t;

	typedef enum logic [2:0] {
		EV_ROOT_CHAR,
		EV_ROOT_DONE,
		EV_TOP_CHAR,
		EV_TOP_DONE,
		EV_GRANDCHILD,
		EV_SCAN_DONE
	} event_kind_t;

	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_QUEST = 8'h3F;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_LBRK  = 8'h5B;
	localparam logic [7:0] CH_RBRK  = 8'h5D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;

	localparam logic [2:0] CDATA_TAIL_LEN = 3'd6;

	typedef struct packed {
		logic        valid;
		event_kind_t kind;
		logic [7:0]  name_char;
		logic        self_closing;
		logic        scan_ok;
		logic [15:0] deepest;
		logic [23:0] tops_total;
		logic        end_of_run;
	} result_t;

	// bytes that follow "<![" to open a CDATA section
	function automatic logic [7:0] cdata_tail(input logic [2:0] idx);
		logic [7:0] ch;
		case (idx)
			3'd0:    ch = 8'h43; // C
			3'd1:    ch = 8'h44; // D
			3'd2:    ch = 8'h41; // A
			3'd3:    ch = 8'h54; // T
			3'd4:    ch = 8'h41; // A
			3'd5:    ch = CH_LBRK;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	function automatic logic is_space(input logic [7:0] b);
		return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
	endfunction

endpackage

/* hdl/xts_scan.sv */
module xts_scan #(
	parameter int DEPTH_BITS     = 16,
	parameter int TOP_COUNT_BITS = 24
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  logic [7:0]       text_byte,
	input  logic             is_last,
	output xts_pkg::result_t res_a,
	output xts_pkg::result_t res_b
);
	import xts_pkg::*;

	scan_mode_t                mode_q, mode_d, mode_n;
	logic [DEPTH_BITS-1:0]     depth_q, depth_n, depth_inc;
	logic [DEPTH_BITS-1:0]     deepest_q, deepest_n;
	logic [2:0]                match_q, match_d;
	logic [7:0]                prev_q;
	logic [TOP_COUNT_BITS-1:0] tops_q, tops_n;
	logic                      root_named_q, root_named_n;
	logic                      name_empty_q, name_empty_d, name_empty_n;
	logic                      failed_q, failed_n;
	logic                      do_open, do_name, do_close, self_cl;
	logic [32:0]               deep_w, tops_w;

	// next mode and decode of the byte
	always_comb begin
		mode_d       = mode_q;
		match_d      = match_q;
		name_empty_d = name_empty_q;
		do_open      = 1'b0;
		do_name      = 1'b0;
		do_close     = 1'b0;
		unique case (mode_q)
			M_TEXT: begin
				if (text_byte == CH_LT) begin
					mode_d       = M_LT;
					name_empty_d = 1'b1;
				end
			end
			M_LT: begin
				if (text_byte == CH_QUEST)      mode_d = M_PI;
				else if (text_byte == CH_BANG)  mode_d = M_BANG;
				else if (text_byte == CH_SLASH) mode_d = M_CLOSE;
				else if (text_byte == CH_GT)    do_open = 1'b1;
				else if (is_space(text_byte))   mode_d = M_ATTR;
				else begin
					do_name = 1'b1;
					mode_d  = M_NAME;
				end
			end
			M_PI: begin
				if (text_byte == CH_GT && prev_q == CH_QUEST) mode_d = M_TEXT;
			end
			M_BANG: begin
				if (text_byte == CH_DASH) mode_d = M_BANG_DASH;
				else if (text_byte == CH_LBRK) begin
					mode_d  = M_CDATA_OPEN;
					match_d = 3'd0;
				end else if (text_byte == CH_GT) mode_d = M_TEXT;
				else mode_d = M_DECL;
			end
			M_BANG_DASH: begin
				if (text_byte == CH_DASH) begin
					mode_d  = M_COMMENT;
					match_d = 3'd2;
				end else if (text_byte == CH_GT) mode_d = M_TEXT;
				else mode_d = M_DECL;
			end
			M_COMMENT, M_CDATA: begin
				if (text_byte == CH_GT && match_q >= 3'd2) begin
					mode_d  = M_TEXT;
					match_d = 3'd0;
				end else if (text_byte == ((mode_q == M_COMMENT) ? CH_DASH : CH_RBRK)) begin
					if (match_q < 3'd2) match_d = match_q + 3'd1;
				end else begin
					match_d = 3'd0;
				end
			end
			M_CDATA_OPEN: begin
				if (match_q < CDATA_TAIL_LEN && text_byte == cdata_tail(match_q)) begin
					if (match_q == CDATA_TAIL_LEN - 3'd1) begin
						mode_d  = M_CDATA;
						match_d = 3'd0;
					end else begin
						match_d = match_q + 3'd1;
					end
				end else if (text_byte == CH_GT) begin
					mode_d  = M_TEXT;
					match_d = 3'd0;
				end else begin
					mode_d  = M_DECL;
					match_d = 3'd0;
				end
			end
			M_DECL: begin
				if (text_byte == CH_GT) mode_d = M_TEXT;
			end
			M_CLOSE: begin
				if (text_byte == CH_GT) do_close = 1'b1;
			end
			M_NAME: begin
				if (text_byte == CH_GT) do_open = 1'b1;
				else if (is_space(text_byte) || text_byte == CH_SLASH) mode_d = M_ATTR;
				else do_name = 1'b1;
			end
			M_ATTR: begin
				if (text_byte == CH_GT) do_open = 1'b1;
			end
			default: mode_d = M_HALT;
		endcase
	end

	// counters and events
	always_comb begin
		mode_n       = mode_d;
		depth_n      = depth_q;
		deepest_n    = deepest_q;
		tops_n       = tops_q;
		root_named_n = root_named_q;
		name_empty_n = name_empty_d;
		failed_n     = failed_q;
		self_cl      = (prev_q == CH_SLASH);
		depth_inc    = depth_q + DEPTH_BITS'(1);
		res_a        = '0;
		res_b        = '0;

		if (do_name) begin
			name_empty_n = 1'b0;
			if (depth_q == '0) begin
				res_a.valid     = 1'b1;
				res_a.kind      = EV_ROOT_CHAR;
				res_a.name_char = text_byte;
			end else if (depth_q == DEPTH_BITS'(1)) begin
				res_a.valid     = 1'b1;
				res_a.kind      = EV_TOP_CHAR;
				res_a.name_char = text_byte;
			end
		end

		if (do_open) begin
			if (&depth_q) begin
				failed_n = 1'b1;
				mode_n   = M_HALT;
			end else begin
				if (depth_inc > deepest_q) deepest_n = depth_inc;
				if (depth_q == '0) begin
					root_named_n       = !name_empty_q;
					res_a.valid        = 1'b1;
					res_a.kind         = EV_ROOT_DONE;
					res_a.self_closing = self_cl;
				end else if (depth_q == DEPTH_BITS'(1)) begin
					if (!(&tops_q)) tops_n = tops_q + TOP_COUNT_BITS'(1);
					res_a.valid        = 1'b1;
					res_a.kind         = EV_TOP_DONE;
					res_a.self_closing = self_cl;
				end else if (depth_q == DEPTH_BITS'(2) && tops_q != '0) begin
					res_a.valid = 1'b1;
					res_a.kind  = EV_GRANDCHILD;
				end
				depth_n = self_cl ? depth_q : depth_inc;
				mode_n  = M_TEXT;
			end
		end

		if (do_close) begin
			if (depth_q == '0) begin
				failed_n = 1'b1;
				mode_n   = M_HALT;
			end else begin
				depth_n = depth_q - DEPTH_BITS'(1);
				mode_n  = M_TEXT;
			end
		end

		// saturate to the fixed result widths
		deep_w = 33'(deepest_n);
		tops_w = 33'(tops_n);
		if (is_last) begin
			res_b.valid      = 1'b1;
			res_b.kind       = EV_SCAN_DONE;
			res_b.scan_ok    = !failed_n && root_named_n && depth_n == '0 &&
			                   (mode_n == M_TEXT || mode_n == M_LT);
			res_b.deepest    = (deep_w > 33'h0_FFFF) ? 16'hFFFF : deep_w[15:0];
			res_b.tops_total = (tops_w > 33'hFF_FFFF) ? 24'hFF_FFFF : tops_w[23:0];
			res_b.end_of_run = 1'b1;
		end
		res_a.end_of_run = res_a.valid && !is_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= M_TEXT;
			depth_q      <= '0;
			deepest_q    <= '0;
			match_q      <= '0;
			prev_q       <= '0;
			tops_q       <= '0;
			root_named_q <= 1'b0;
			name_empty_q <= 1'b1;
			failed_q     <= 1'b0;
		end else if (advance) begin
			if (is_last) begin
				// back to the reset state for the next document
				mode_q       <= M_TEXT;
				depth_q      <= '0;
				deepest_q    <= '0;
				match_q      <= '0;
				prev_q       <= '0;
				tops_q       <= '0;
				root_named_q <= 1'b0;
				name_empty_q <= 1'b1;
				failed_q     <= 1'b0;
			end else begin
				mode_q       <= mode_n;
				depth_q      <= depth_n;
				deepest_q    <= deepest_n;
				match_q      <= match_d;
				prev_q       <= text_byte;
				tops_q       <= tops_n;
				root_named_q <= root_named_n;
				name_empty_q <= name_empty_n;
				failed_q     <= failed_n;
			end
		end
	end

endmodule

/* hdl/xts_out_queue.sv */
module xts_out_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [1:0]       push_n,
	input  xts_pkg::result_t din_a,
	input  xts_pkg::result_t din_b,
	input  logic             pop,
	output xts_pkg::result_t dout,
	output logic             not_empty,
	output logic             room_for_two
);
	import xts_pkg::*;

	result_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_q, rd_q;
	logic [QPTR_BITS:0]   count_q;
	logic                 do_pop;

	assign not_empty    = (count_q != '0);
	assign room_for_two = (count_q <= (QPTR_BITS+1)'(QUEUE_DEPTH - 2));
	assign dout         = entry_q[rd_q];
	assign do_pop       = pop && not_empty;

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) entry_q[wr_q] <= din_a;
		if (push_n == 2'd2) entry_q[wr_q + QPTR_BITS'(1)] <= din_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + QPTR_BITS'(push_n);
			rd_q    <= rd_q + QPTR_BITS'(do_pop);
			count_q <= count_q + (QPTR_BITS+1)'(push_n) - (QPTR_BITS+1)'(do_pop);
		end
	end

endmodule

/* hdl/xml_top_level_scanner.sv */
// XML tag depth scanner. One document byte enters per request on the s_ side,
// with tlast on the final byte; the block tracks tag nesting, skips
// instructions, comments, CDATA and declarations, and streams events on the
// m_ side: root and top name bytes, tag-done events, grandchild events and a
// closing scan-done report. It takes one byte per clock unless stalled: a byte
// is held in the input register, where the mode machine and counters handle
// it, and its results land in a four-entry result queue, which drives the m_
// side. Most bytes give no result or one; the final byte of a document may
// give two, which leave the queue one after the other. The input stalls only
// while the result queue holds more than two results.
module xml_top_level_scanner #(
	parameter int DEPTH_BITS     = 16,
	parameter int TOP_COUNT_BITS = 24
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [7:0]                      s_tdata,  // text_byte
	input  logic                            s_tlast,  // is_last
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// name_char, self_closing, scan_ok, deepest, tops_total, zero fill
	output logic [xts_pkg::TDATA_BITS-1:0]  m_tdata,
	output logic [2:0]                      m_tuser,  // event_kind
	output logic                            m_tlast   // end_of_run
);
	import xts_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       advance, room;
	logic [1:0] push_n;
	result_t    res_a, res_b, first, head;

	assign advance  = valid_s1 && room;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	xts_scan #(
		.DEPTH_BITS    (DEPTH_BITS),
		.TOP_COUNT_BITS(TOP_COUNT_BITS)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.text_byte(byte_s1),
		.is_last  (last_s1),
		.res_a    (res_a),
		.res_b    (res_b)
	);

	// pack the valid results to the front
	assign first  = res_a.valid ? res_a : res_b;
	assign push_n = advance ? (2'(res_a.valid) + 2'(res_b.valid)) : 2'd0;

	xts_out_queue u_queue (
		.clk         (clk),
		.arst_n      (arst_n),
		.push_n      (push_n),
		.din_a       (first),
		.din_b       (res_b),
		.pop         (m_tready),
		.dout        (head),
		.not_empty   (m_tvalid),
		.room_for_two(room)
	);

	assign m_tuser = head.kind;
	assign m_tlast = head.end_of_run;
	assign m_tdata = {6'd0, head.tops_total, head.deepest, head.scan_ok,
	                  head.self_closing, head.name_char};

endmodule

/* hdl/xts_checker.sv */
module xts_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [xts_pkg::TDATA_BITS-1:0] m_tdata,
	input logic [2:0]                     m_tuser,
	input logic                           m_tlast
);
	import xts_pkg::*;

	// hold a stalled result
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
		&& $stable(m_tlast))
		else $error("result changed while stalled");

	// the scan report always closes the run of its byte
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == EV_SCAN_DONE |-> m_tlast)
		else $error("scan-done result without tlast");

	// only name-byte events carry a character
	a_name_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != EV_ROOT_CHAR && m_tuser != EV_TOP_CHAR
		|-> m_tdata[7:0] == 8'd0)
		else $error("name byte on a non-name event");

	// report fields stay clear outside the scan report
	a_report_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != EV_SCAN_DONE |-> m_tdata[49:9] == '0)
		else $error("report fields set on a non-report event");

endmodule

bind xml_top_level_scanner xts_checker u_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser),
	.m_tlast (m_tlast)
);

/* tb/sv/tb.sv */
`timescale 1ns / 100ps

module tb;
	import xts_pkg::*;

	localparam int ITEM_TARGET = 950;
	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_CYCLES = 200;
	localparam int IDLE_HEAVY  = 82;
	localparam int IDLE_LIGHT  = 8;

	// stimulus phases, chosen by how far the feed has got
	localparam int PH_FREE       = 0;
	localparam int PH_SEND_IDLE  = 1;
	localparam int PH_RECV_STALL = 2;
	localparam int PH_BOTH       = 3;
	localparam int PH_PRESSURE   = 4;

	localparam logic [47:0] CDATA_KEY = "CDATA[";

	typedef struct packed {
		logic [7:0] b;
		logic       last;
	} text_t;

	typedef struct packed {
		event_kind_t           kind;
		logic [TDATA_BITS-1:0] data;
		logic                  last;
	} scan_event_t;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [7:0]            s_tdata  = 8'h00;
	logic                  s_tlast  = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [TDATA_BITS-1:0] m_tdata;
	logic [2:0]            m_tuser;
	logic                  m_tlast;

	text_t       text_feed[$];
	scan_event_t scan_events_due[$];
	text_t       next_item;
	logic        send_gap;
	int          total_items  = 1;
	int          sent_cnt     = 0;
	int          phase;
	int          hold_left    = 0;
	logic        held         = 1'b0;
	int          quiet_cycles = 0;
	int          n_errors     = 0;

	// scanner state as the predictor sees it
	scan_mode_t  sm;
	logic [15:0] nest;
	logic [15:0] deep_max;
	logic [2:0]  mprog;
	logic [7:0]  prev_b;
	logic [23:0] tops;
	logic        root_ok;
	logic        name_empty;
	logic        failed;

	xml_top_level_scanner u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	assign phase = (sent_cnt * 5) / total_items;

	// ---------------------------------------------------------------- predictor

	function automatic logic is_blank(logic [7:0] b);
		return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
	endfunction

	function automatic void clear_scanner();
		sm         = M_TEXT;
		nest       = '0;
		deep_max   = '0;
		mprog      = '0;
		prev_b     = '0;
		tops       = '0;
		root_ok    = 1'b0;
		name_empty = 1'b1;
		failed     = 1'b0;
	endfunction

	function automatic void post_event(event_kind_t k, logic [7:0] ch, logic self, logic ok,
	                                   logic [15:0] deep, logic [23:0] tcount);
		scan_event_t ev;
		ev.kind        = k;
		ev.data        = '0;
		ev.data[7:0]   = ch;
		ev.data[8]     = self;
		ev.data[9]     = ok;
		ev.data[25:10] = deep;
		ev.data[49:26] = tcount;
		ev.last        = 1'b0;
		scan_events_due.push_back(ev);
	endfunction

	function automatic void note_name_byte(logic [7:0] b);
		name_empty = 1'b0;
		if (nest == 0)
			post_event(EV_ROOT_CHAR, b, 1'b0, 1'b0, '0, '0);
		else if (nest == 1)
			post_event(EV_TOP_CHAR, b, 1'b0, 1'b0, '0, '0);
	endfunction

	function automatic void tag_open();
		logic        self;
		logic [15:0] d;
		self = (prev_b == CH_SLASH);
		if (nest == 16'hFFFF) begin
			failed = 1'b1;
			sm     = M_HALT;
			return;
		end
		d    = nest + 16'd1;
		nest = d;
		if (d > deep_max)
			deep_max = d;
		if (d == 1) begin
			root_ok = !name_empty;
			post_event(EV_ROOT_DONE, 8'h00, self, 1'b0, '0, '0);
		end else if (d == 2) begin
			if (tops != '1)
				tops = tops + 24'd1;
			post_event(EV_TOP_DONE, 8'h00, self, 1'b0, '0, '0);
		end else if (d == 3 && tops != 0) begin
			post_event(EV_GRANDCHILD, 8'h00, 1'b0, 1'b0, '0, '0);
		end
		if (self)
			nest = nest - 16'd1;
		sm = M_TEXT;
	endfunction

	function automatic void predict_byte(logic [7:0] b, logic last);
		int          n_before;
		logic        ok;
		scan_event_t ev;
		n_before = scan_events_due.size();
		case (sm)
			M_TEXT: begin
				if (b == CH_LT) begin
					sm         = M_LT;
					name_empty = 1'b1;
				end
			end
			M_LT: begin
				if (b == CH_QUEST)
					sm = M_PI;
				else if (b == CH_BANG)
					sm = M_BANG;
				else if (b == CH_SLASH)
					sm = M_CLOSE;
				else if (b == CH_GT)
					tag_open();
				else if (is_blank(b))
					sm = M_ATTR;
				else begin
					note_name_byte(b);
					sm = M_NAME;
				end
			end
			M_PI: begin
				if (b == CH_GT && prev_b == CH_QUEST)
					sm = M_TEXT;
			end
			M_BANG: begin
				if (b == CH_DASH)
					sm = M_BANG_DASH;
				else if (b == CH_LBRK) begin
					sm    = M_CDATA_OPEN;
					mprog = '0;
				end else if (b == CH_GT)
					sm = M_TEXT;
				else
					sm = M_DECL;
			end
			M_BANG_DASH: begin
				if (b == CH_DASH) begin
					sm    = M_COMMENT;
					mprog = 3'd2;
				end else if (b == CH_GT)
					sm = M_TEXT;
				else
					sm = M_DECL;
			end
			M_COMMENT, M_CDATA: begin
				// same closer search, on '-' for comments and ']' for CDATA
				if (b == CH_GT && mprog >= 2) begin
					sm    = M_TEXT;
					mprog = '0;
				end else if (b == ((sm == M_COMMENT) ? CH_DASH : CH_RBRK)) begin
					if (mprog < 2)
						mprog = mprog + 3'd1;
				end else
					mprog = '0;
			end
			M_CDATA_OPEN: begin
				if (mprog < CDATA_TAIL_LEN && b == CDATA_KEY[8 * (5 - int'(mprog)) +: 8]) begin
					mprog = mprog + 3'd1;
					if (mprog == CDATA_TAIL_LEN) begin
						sm    = M_CDATA;
						mprog = '0;
					end
				end else begin
					sm    = (b == CH_GT) ? M_TEXT : M_DECL;
					mprog = '0;
				end
			end
			M_DECL: begin
				if (b == CH_GT)
					sm = M_TEXT;
			end
			M_CLOSE: begin
				if (b == CH_GT) begin
					if (nest == 0) begin
						failed = 1'b1;
						sm     = M_HALT;
					end else begin
						nest = nest - 16'd1;
						sm   = M_TEXT;
					end
				end
			end
			M_NAME: begin
				if (b == CH_GT)
					tag_open();
				else if (is_blank(b) || b == CH_SLASH)
					sm = M_ATTR;
				else
					note_name_byte(b);
			end
			M_ATTR: begin
				if (b == CH_GT)
					tag_open();
			end
			default: sm = M_HALT;
		endcase
		prev_b = b;
		if (last) begin
			ok = !failed && root_ok && nest == 0 && (sm == M_TEXT || sm == M_LT);
			post_event(EV_SCAN_DONE, 8'h00, 1'b0, ok, deep_max, tops);
			clear_scanner();
		end
		// flag the final result of this byte
		if (scan_events_due.size() > n_before) begin
			ev      = scan_events_due.pop_back();
			ev.last = 1'b1;
			scan_events_due.push_back(ev);
		end
	endfunction

	// ---------------------------------------------------------------- stimulus

	function automatic void put_byte(logic [7:0] b);
		text_feed.push_back({b, 1'b0});
	endfunction

	function automatic void put_text(string s);
		for (int i = 0; i < s.len(); i++)
			put_byte(s[i]);
	endfunction

	function automatic void end_doc();
		text_t t;
		t      = text_feed.pop_back();
		t.last = 1'b1;
		text_feed.push_back(t);
	endfunction

	function automatic logic [7:0] pick_blank();
		return ($urandom_range(5) == 5) ? CH_SPACE : CH_TAB + 8'($urandom_range(4));
	endfunction

	function automatic logic [7:0] pick_letter();
		return 8'h61 + 8'($urandom_range(25));
	endfunction

	function automatic int put_name();
		int         len;
		logic [7:0] c;
		len = ($urandom_range(7) == 0) ? 0 : $urandom_range(4, 1);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(7) == 0) begin
				do
					c = 8'($urandom_range(255));
				while (is_blank(c) || c == CH_SLASH || c == CH_GT ||
				       (i == 0 && (c == CH_QUEST || c == CH_BANG)));
			end else
				c = pick_letter();
			put_byte(c);
		end
		return len;
	endfunction

	function automatic void put_open(logic self);
		int   len;
		logic attrs;
		put_byte(CH_LT);
		len   = put_name();
		attrs = ($urandom_range(2) == 0);
		if (attrs) begin
			repeat ($urandom_range(2, 1)) begin
				put_byte(pick_blank());
				put_byte(pick_letter());
				put_text("=\"");
				repeat ($urandom_range(3))
					put_byte(($urandom_range(5) == 0) ? CH_SLASH : pick_letter());
				put_byte(8'h22);
			end
			if ($urandom_range(3) == 0)
				put_byte(pick_blank());
		end
		if (self) begin
			// an empty name needs a gap, else "</" reads as a closing tag
			if (len == 0 && !attrs)
				put_byte(CH_SPACE);
			put_text("/>");
		end else
			put_byte(CH_GT);
	endfunction

	function automatic void put_close();
		put_text("</");
		void'(put_name());
		put_byte(CH_GT);
	endfunction

	// body of a skipped construct that never completes its closer early
	function automatic void put_body(logic [7:0] mark, int p0, int need);
		int         p;
		logic [7:0] c;
		p = p0;
		repeat ($urandom_range(6)) begin
			case ($urandom_range(3))
				0:       c = mark;
				1:       c = CH_GT;
				2:       c = CH_SPACE;
				default: c = pick_letter();
			endcase
			if (c == CH_GT && p >= need)
				c = pick_letter();
			p = (c == mark) ? ((p < need) ? p + 1 : need) : 0;
			put_byte(c);
		end
	endfunction

	function automatic void put_filler();
		case ($urandom_range(5))
			0: begin
				if ($urandom_range(3) == 0)
					put_text("<?>");
				else begin
					put_text("<?");
					put_body(CH_QUEST, 1, 1);
					put_text("?>");
				end
			end
			1: begin
				if ($urandom_range(3) == 0)
					put_text("<!-->");
				else begin
					put_text("<!--");
					put_body(CH_DASH, 2, 2);
					put_text("-->");
				end
			end
			2: begin
				put_text("<![CDATA[");
				put_body(CH_RBRK, 0, 2);
				put_text("]]>");
			end
			3: begin
				case ($urandom_range(4))
					0: put_text("<!>");
					1: put_text("<!->");
					2: put_text("<![>");
					3: put_text("<![CDA>");
					default: begin
						put_text("<!");
						put_byte(pick_letter());
						repeat ($urandom_range(6))
							put_byte(($urandom_range(3) == 0) ? CH_SPACE : pick_letter());
						put_byte(CH_GT);
					end
				endcase
			end
			default: begin
				// plain text, stray '>' included
				repeat ($urandom_range(5, 1)) begin
					case ($urandom_range(4))
						0:       put_byte(pick_blank());
						1:       put_byte(CH_GT);
						2:       put_byte(8'($urandom_range(255, 128)));
						default: put_byte(pick_letter());
					endcase
				end
			end
		endcase
	endfunction

	// random walk over nesting levels instead of recursion
	function automatic void put_tree();
		int   lvl;
		int   budget;
		int   chance;
		logic self;
		self = ($urandom_range(5) == 0);
		put_open(self);
		lvl    = self ? 0 : 1;
		budget = $urandom_range(10, 2);
		while (lvl > 0) begin
			if ($urandom_range(2) == 0)
				put_filler();
			chance = (lvl == 1) ? 70 : (lvl == 2) ? 50 : 30;
			if (lvl < 5 && budget > 0 && $urandom_range(99) < chance) begin
				budget = budget - 1;
				self   = ($urandom_range(2) == 0);
				put_open(self);
				if (!self)
					lvl = lvl + 1;
			end else begin
				put_close();
				lvl = lvl - 1;
			end
		end
	endfunction

	function automatic void put_document();
		if ($urandom_range(1) == 0)
			put_text("<?xml version='1.0'?>");
		repeat ($urandom_range(2))
			put_filler();
		put_tree();
		if ($urandom_range(9) == 0)
			put_tree();
		if ($urandom_range(1) == 0)
			put_filler();
	endfunction

	function automatic void build_stimulus();
		int start;
		int cut;
		// overlapping openers and closers, self-closing root, 0x00 and 0xFF
		put_text("<?><!--><a/>");
		end_doc();
		// closing tag with nothing open
		put_byte(8'h00);
		put_text("</>");
		end_doc();
		// lone '<' as the last byte
		put_byte(CH_LT);
		end_doc();
		put_text("<r><t");
		put_byte(8'hFF);
		put_text("><g/></></>");
		end_doc();

		while (text_feed.size() < ITEM_TARGET) begin
			if ($urandom_range(3) != 0) begin
				put_document();
			end else begin
				case ($urandom_range(4))
					0: begin
						repeat ($urandom_range(12, 1))
							put_byte(8'($urandom_range(255)));
					end
					1: begin
						// cut a document short, often inside a construct
						start = text_feed.size();
						put_document();
						cut = $urandom_range(text_feed.size() - start, 1);
						while (text_feed.size() > start + cut)
							void'(text_feed.pop_back());
					end
					2: begin
						put_close();
						put_document();
					end
					3: begin
						put_document();
						put_close();
					end
					default: begin
						put_document();
						put_text("<!-- open");
					end
				endcase
			end
			end_doc();
		end
	endfunction

	// ---------------------------------------------------------------- driver

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= 8'h00;
			s_tlast  <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_byte(s_tdata, s_tlast);
				sent_cnt <= sent_cnt + 1;
			end
			if (!s_tvalid || s_tready) begin
				send_gap = (phase == PH_SEND_IDLE && $urandom_range(99) < IDLE_HEAVY) ||
				           (phase == PH_BOTH && $urandom_range(99) < IDLE_LIGHT);
				if (text_feed.size() != 0 && !send_gap) begin
					next_item = text_feed.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= next_item.b;
					s_tlast  <= next_item.last;
				end else
					s_tvalid <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------- receiver

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready  <= 1'b0;
			hold_left <= 0;
			held      <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else if (phase == PH_PRESSURE && !held) begin
			// hold off long enough for the result queue to back up the input
			hold_left <= HOLD_CYCLES;
			held      <= 1'b1;
			m_tready  <= 1'b0;
		end else if (phase == PH_RECV_STALL)
			m_tready <= ($urandom_range(99) >= IDLE_HEAVY);
		else if (phase == PH_BOTH)
			m_tready <= ($urandom_range(99) >= IDLE_LIGHT);
		else
			m_tready <= 1'b1;
	end

	// ---------------------------------------------------------------- monitor

	always @(posedge clk) begin : check_events
		scan_event_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (scan_events_due.size() == 0) begin
				n_errors = n_errors + 1;
				if (n_errors <= 10)
					$display("unexpected result: kind %0d data %h last %b",
					         m_tuser, m_tdata, m_tlast);
			end else begin
				want = scan_events_due.pop_front();
				if (m_tuser !== want.kind || m_tdata !== want.data || m_tlast !== want.last) begin
					n_errors = n_errors + 1;
					if (n_errors <= 10) begin
						$write("mismatch: kind %0d/%0d char %h/%h self %b/%b ok %b/%b ",
						       m_tuser, want.kind, m_tdata[7:0], want.data[7:0],
						       m_tdata[8], want.data[8], m_tdata[9], want.data[9]);
						$display("deepest %0d/%0d tops %0d/%0d fill %h/%h last %b/%b",
						         m_tdata[25:10], want.data[25:10],
						         m_tdata[49:26], want.data[49:26],
						         m_tdata[TDATA_BITS-1:50], want.data[TDATA_BITS-1:50],
						         m_tlast, want.last);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		clear_scanner();
		build_stimulus();
		total_items = text_feed.size();
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		while (text_feed.size() != 0 || s_tvalid)
			@(posedge clk);
		while (scan_events_due.size() != 0)
			@(posedge clk);
		// allow for any stray result behind the last one
		repeat (20) @(posedge clk);
		if (n_errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
